[rtl/mskt_pkg.sv]
// ----------------------------------------------------------------------------
// mskt_pkg: shared types and constants for the motor state Kalman tracker
// Fixed-width field constants, register indexes and controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package mskt_pkg;

   localparam int unsigned STAMP_W = 48;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_Q_POS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_VEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_MEAS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd3;

   localparam logic FUNC_CORRECT = 1'b0;
   localparam logic FUNC_QUERY   = 1'b1;

   // micro-operations executed by the datapath
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // latch item, compute dt and checks
      OP_MUL_X,     // x0 += dt*x1
      OP_MUL_A00,   // a00 = p0 + dt*p2
      OP_MUL_A01,   // a01 = p1 + dt*p3
      OP_MUL_P0,    // pre p0 = a00 + a01*dt + qpos
      OP_MUL_P2,    // pre p2 = p2 + p3*dt, p3 += qvel, commit
      OP_DIV_START, // start gain divisions
      OP_DIV_STEP,
      OP_UPD_X0,
      OP_UPD_X1,
      OP_UPD_P0,
      OP_UPD_P1,
      OP_UPD_P2,
      OP_UPD_P3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_sel;   // 0: k0, 1: k1
   } cmd_type;

   typedef struct packed {
      logic pred_ok;     // prediction allowed
      logic first;       // first prediction only records time
      logic div_done;
   } sts_type;

endpackage

[rtl/motor_state_kalman_tracker.sv]
// ----------------------------------------------------------------------------
// motor_state_kalman_tracker: two-state constant-velocity Kalman tracker
// Q-format position/velocity tracker with timed predict and measurement update.
// ----------------------------------------------------------------------------
// A skipped item or a first prediction without update goes straight to the result;
// a query runs the predict steps; a correction runs predict (skipped on a first
// prediction) and update, with two serial divisions of 32+FRAC_BITS+1 quotient bits.
// One item at a time: the next beat is taken after the result beat is taken.
// Synchronous reset restores registers to defaults and state to its initial
// values (identity pre covariance, zero vectors and times).
module motor_state_kalman_tracker #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // stamp[47:0], measured[79:48], which[80]
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // estimate[31:0], predicted[32], corrected[33]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import mskt_pkg::*;

   logic [31:0] qpos_ff, qvel_ff, rmeas_ff, tout_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic signed [31:0] est;
   logic        pred, corr;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff  <= 32'd655;
         qvel_ff  <= 32'd65536;
         rmeas_ff <= 32'd6554;
         tout_ff  <= 32'd7209;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_Q_POS:   qpos_ff  <= csr_data;
            CSR_Q_VEL:   qvel_ff  <= csr_data;
            CSR_R_MEAS:  rmeas_ff <= csr_data;
            CSR_TIMEOUT: tout_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   mskt_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_func(req_tuser),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_pred(pred), .out_corr(corr), .cmd, .sts
   );

   mskt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_func(req_tuser), .in_stamp(req_tdata[47:0]),
      .in_measured(req_tdata[79:48]), .in_which(req_tdata[80]),
      .q_pos(qpos_ff), .q_vel(qvel_ff), .r_meas(rmeas_ff), .timeout(tout_ff),
      .est
   );

   assign rsp_tdata = {6'd0, corr, pred, est};

   a_corr_implies_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[32])
      else $error("corrected without prediction");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");
   a_rsp_after_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result repeated");
endmodule

[rtl/mskt_datapath.sv]
// ----------------------------------------------------------------------------
// mskt_datapath: state, one shared multiplier and a serial divider
// Executes one micro-operation per command; saturating Q arithmetic.
// ----------------------------------------------------------------------------
module mskt_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mskt_pkg::cmd_type          cmd,
   output mskt_pkg::sts_type          sts,
   input  logic                       in_func,
   input  logic [mskt_pkg::STAMP_W-1:0] in_stamp,
   input  logic signed [31:0]         in_measured,
   input  logic                       in_which,
   input  logic [31:0]                q_pos,
   input  logic [31:0]                q_vel,
   input  logic [31:0]                r_meas,
   input  logic [31:0]                timeout,
   output logic signed [31:0]         est
);
   import mskt_pkg::*;

   localparam int DIV_W = 32 + FRAC_BITS + 1;
   localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0] prex_ff [2];
   logic signed [31:0] postx_ff [2];
   logic signed [31:0] prep_ff [4];
   logic signed [31:0] postp_ff [4];
   logic [STAMP_W-1:0] tpred_ff, tcorr_ff;
   logic signed [31:0] dt_ff, a00_ff, a01_ff, k0_ff, k1_ff, innov_ff, z_ff;
   logic               func_ff, which_ff, ok_ff, first_ff;

   // divider
   logic [DIV_W-1:0]   dnum_ff, dq_ff;
   logic [33:0]        drem_ff, dden_ff;
   logic               dneg_ff, dbusy_ff, ddone_ff;
   logic [6:0]         dcnt_ff;

   function automatic logic signed [31:0] sat(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // shared multiplier: a*b rounded, result saturated
   logic signed [31:0] ma, mb, mq;
   logic signed [63:0] mp;
   always_comb begin
      mp = ma * mb + RND;
      mq = sat(66'(mp >>> FRAC_BITS));
   end

   always_comb begin
      ma = dt_ff; mb = postx_ff[1];
      case (cmd.op)
         OP_MUL_X:   begin ma = dt_ff;  mb = postx_ff[1]; end
         OP_MUL_A00: begin ma = dt_ff;  mb = postp_ff[2]; end
         OP_MUL_A01: begin ma = dt_ff;  mb = postp_ff[3]; end
         OP_MUL_P0:  begin ma = a01_ff; mb = dt_ff; end
         OP_MUL_P2:  begin ma = postp_ff[3]; mb = dt_ff; end
         OP_UPD_X0:  begin ma = k0_ff; mb = innov_ff; end
         OP_UPD_X1:  begin ma = k1_ff; mb = innov_ff; end
         OP_UPD_P0:  begin ma = k0_ff; mb = prep_ff[0]; end
         OP_UPD_P1:  begin ma = k0_ff; mb = prep_ff[1]; end
         OP_UPD_P2:  begin ma = k1_ff; mb = prep_ff[0]; end
         OP_UPD_P3:  begin ma = k1_ff; mb = prep_ff[1]; end
         default:    begin ma = dt_ff; mb = postx_ff[1]; end
      endcase
   end

   // load-time checks
   logic [STAMP_W-1:0] tc_eff, dtick, dcorr;
   logic               later, stale;
   logic [31:0]        dsat;
   logic signed [31:0] dt_in;
   logic [63:0]        dsh;
   always_comb begin
      tc_eff = (in_func == FUNC_CORRECT) ? in_stamp : tcorr_ff;
      later  = in_stamp > tpred_ff;
      dcorr  = in_stamp - tc_eff;
      stale  = (tc_eff != '0) && (in_stamp > tc_eff) && (dcorr > STAMP_W'(timeout));
      dtick  = in_stamp - tpred_ff;
      dsat   = (dtick > STAMP_W'(32'h7fffffff)) ? 32'h7fffffff : dtick[31:0];
      if (FRAC_BITS >= 16) dsh = {32'd0, dsat} << (FRAC_BITS - 16);
      else                 dsh = {32'd0, dsat} >> (16 - FRAC_BITS);
      dt_in = (dsh > 64'h7fffffff) ? 32'sh7fffffff : dsh[31:0];
   end

   logic signed [33:0] s_val;
   assign s_val = 34'(prep_ff[0]) + 34'(signed'({1'b0, r_meas}));

   // division step
   logic [33:0] rtry;
   assign rtry = {drem_ff[32:0], dnum_ff[DIV_W-1]};

   logic signed [31:0] dres;
   logic [DIV_W:0]     dqs;
   always_comb begin
      dqs = {1'b0, dq_ff};
      if (dqs > (DIV_W+1)'(32'h7fffffff) + (dneg_ff ? 1 : 0))
         dres = dneg_ff ? 32'sh80000000 : 32'sh7fffffff;
      else
         dres = dneg_ff ? -$signed(dq_ff[31:0]) : $signed(dq_ff[31:0]);
   end

   assign sts.pred_ok  = ok_ff;
   assign sts.first    = first_ff;
   assign sts.div_done = ddone_ff;

   logic signed [31:0] num_sel;
   logic [33:0]        s_abs;
   assign num_sel = cmd.div_sel ? prep_ff[1] : prep_ff[0];
   assign s_abs   = s_val[33] ? 34'(-s_val) : 34'(s_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         prex_ff  <= '{default: '0};
         postx_ff <= '{default: '0};
         prep_ff  <= '{ONE, 32'sd0, 32'sd0, ONE};
         postp_ff <= '{default: '0};
         tpred_ff <= '0;
         tcorr_ff <= '0;
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         ok_ff    <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         case (cmd.op)
            OP_LOAD: begin
               func_ff  <= in_func;
               which_ff <= in_which;
               z_ff     <= in_measured;
               dt_ff    <= dt_in;
               tcorr_ff <= tc_eff;
               first_ff <= (tpred_ff == '0);
               ok_ff    <= later && ((tpred_ff == '0) || !stale);
               if (later && ((tpred_ff == '0) || !stale)) tpred_ff <= in_stamp;
            end
            OP_MUL_X:   prex_ff[0] <= sat(66'(postx_ff[0]) + 66'(mq));
            OP_MUL_A00: a00_ff <= sat(66'(postp_ff[0]) + 66'(mq));
            OP_MUL_A01: a01_ff <= sat(66'(postp_ff[1]) + 66'(mq));
            OP_MUL_P0: begin
               prep_ff[0] <= sat(66'(sat(66'(a00_ff) + 66'(mq)))
                                 + 66'(signed'({1'b0, q_pos})));
               prep_ff[1] <= a01_ff;
               prex_ff[1] <= postx_ff[1];
            end
            OP_MUL_P2: begin
               prep_ff[2] <= sat(66'(postp_ff[2]) + 66'(mq));
               prep_ff[3] <= sat(66'(postp_ff[3]) + 66'(signed'({1'b0, q_vel})));
               postx_ff[0] <= prex_ff[0];
               postx_ff[1] <= postx_ff[1];
               postp_ff[0] <= prep_ff[0];
               postp_ff[1] <= a01_ff;
               postp_ff[2] <= sat(66'(postp_ff[2]) + 66'(mq));
               postp_ff[3] <= sat(66'(postp_ff[3]) + 66'(signed'({1'b0, q_vel})));
            end
            OP_DIV_START: begin
               dnum_ff  <= DIV_W'((num_sel[31] ? 64'(-65'(num_sel)) : 64'(num_sel))
                                  << FRAC_BITS);
               dden_ff  <= s_abs;
               dneg_ff  <= num_sel[31] ^ s_val[33];
               drem_ff  <= '0;
               dq_ff    <= '0;
               dcnt_ff  <= 7'(DIV_W);
               dbusy_ff <= 1'b1;
               innov_ff <= sat(66'(z_ff) - 66'(prex_ff[0]));
            end
            OP_DIV_STEP: begin
               if (dbusy_ff) begin
                  if (rtry >= dden_ff) begin
                     drem_ff <= rtry - dden_ff;
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b1};
                  end else begin
                     drem_ff <= rtry;
                     dq_ff   <= {dq_ff[DIV_W-2:0], 1'b0};
                  end
                  dnum_ff <= {dnum_ff[DIV_W-2:0], 1'b0};
                  dcnt_ff <= dcnt_ff - 7'd1;
                  if (dcnt_ff == 7'd1) begin
                     dbusy_ff <= 1'b0;
                     ddone_ff <= 1'b1;
                  end
               end else if (cmd.div_sel) begin
                  k1_ff <= (s_val == '0) ? 32'sd0 : dres;
               end else begin
                  k0_ff <= (s_val == '0) ? 32'sd0 : dres;
               end
            end
            OP_UPD_X0: postx_ff[0] <= sat(66'(prex_ff[0]) + 66'(mq));
            OP_UPD_X1: postx_ff[1] <= sat(66'(prex_ff[1]) + 66'(mq));
            OP_UPD_P0: postp_ff[0] <= sat(66'(prep_ff[0]) - 66'(mq));
            OP_UPD_P1: postp_ff[1] <= sat(66'(prep_ff[1]) - 66'(mq));
            OP_UPD_P2: postp_ff[2] <= sat(66'(prep_ff[2]) - 66'(mq));
            OP_UPD_P3: postp_ff[3] <= sat(66'(prep_ff[3]) - 66'(mq));
            default: ;
         endcase
      end
   end

   assign est = (func_ff == FUNC_CORRECT) ? postx_ff[0] :
                (which_ff ? prex_ff[1] : prex_ff[0]);
endmodule

[rtl/mskt_ctrl.sv]
// ----------------------------------------------------------------------------
// mskt_ctrl: sequencer for the Kalman tracker
// Accepts one beat, steps the datapath through predict and update, and
// holds the result beat until taken.
// ----------------------------------------------------------------------------
module mskt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_func,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_pred,
   output logic              out_corr,
   output mskt_pkg::cmd_type cmd,
   input  mskt_pkg::sts_type sts
);
   import mskt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_X, S_A00, S_A01, S_P0, S_P2,
      S_D0S, S_D0, S_D0W, S_D1S, S_D1, S_D1W,
      S_UX0, S_UX1, S_UP0, S_UP1, S_UP2, S_UP3, S_OUT
   } state_type;

   state_type state_ff;
   logic      func_ff, valid_ff, pred_ff, corr_ff;

   always_comb begin
      cmd.op = OP_NONE;
      cmd.div_sel = 1'b0;
      case (state_ff)
         S_IDLE: if (in_valid) cmd.op = OP_LOAD;
         S_X:    cmd.op = OP_MUL_X;
         S_A00:  cmd.op = OP_MUL_A00;
         S_A01:  cmd.op = OP_MUL_A01;
         S_P0:   cmd.op = OP_MUL_P0;
         S_P2:   cmd.op = OP_MUL_P2;
         S_D0S:  cmd.op = OP_DIV_START;
         S_D0:   cmd.op = OP_DIV_STEP;
         S_D0W:  cmd.op = OP_DIV_STEP;
         S_D1S:  begin cmd.op = OP_DIV_START; cmd.div_sel = 1'b1; end
         S_D1:   begin cmd.op = OP_DIV_STEP;  cmd.div_sel = 1'b1; end
         S_D1W:  begin cmd.op = OP_DIV_STEP;  cmd.div_sel = 1'b1; end
         S_UX0:  cmd.op = OP_UPD_X0;
         S_UX1:  cmd.op = OP_UPD_X1;
         S_UP0:  cmd.op = OP_UPD_P0;
         S_UP1:  cmd.op = OP_UPD_P1;
         S_UP2:  cmd.op = OP_UPD_P2;
         S_UP3:  cmd.op = OP_UPD_P3;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;
   assign out_pred  = pred_ff;
   assign out_corr  = corr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         pred_ff  <= 1'b0;
         corr_ff  <= 1'b0;
         func_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (in_valid) begin
               func_ff  <= in_func;
               state_ff <= S_CHECK;
            end
            S_CHECK:
               if (!sts.pred_ok || sts.first) begin
                  pred_ff <= sts.pred_ok;
                  corr_ff <= sts.pred_ok && (func_ff == FUNC_CORRECT);
                  state_ff <= (sts.pred_ok && func_ff == FUNC_CORRECT) ? S_D0S : S_OUT;
               end else state_ff <= S_X;
            S_X:   state_ff <= S_A00;
            S_A00: state_ff <= S_A01;
            S_A01: state_ff <= S_P0;
            S_P0:  state_ff <= S_P2;
            S_P2: begin
               pred_ff  <= 1'b1;
               corr_ff  <= (func_ff == FUNC_CORRECT);
               state_ff <= (func_ff == FUNC_CORRECT) ? S_D0S : S_OUT;
            end
            S_D0S: state_ff <= S_D0;
            S_D0:  if (sts.div_done) state_ff <= S_D0W;
            S_D0W: state_ff <= S_D1S;
            S_D1S: state_ff <= S_D1;
            S_D1:  if (sts.div_done) state_ff <= S_D1W;
            S_D1W: state_ff <= S_UX0;
            S_UX0: state_ff <= S_UX1;
            S_UX1: state_ff <= S_UP0;
            S_UP0: state_ff <= S_UP1;
            S_UP1: state_ff <= S_UP2;
            S_UP2: state_ff <= S_UP3;
            S_UP3: state_ff <= S_OUT;
            S_OUT: begin
               if (!valid_ff) valid_ff <= 1'b1;
               else if (out_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
